// File: sv/sgbd_pkg.sv
// Shared constants for the signed Golomb bit decoder.
package sgbd_pkg;

    localparam int CFG_W             = 13;
    localparam int VALUE_W           = 23;
    localparam int MAG_LIMIT         = 4194303;
    localparam int DEF_MAX_QUOTIENT  = 1023;
    localparam int DEF_DIVISOR_WIDTH = 12;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CFG_W-1:0] DIVISOR_RESET = CFG_W'(1);

endpackage

// File: sv/signed_golomb_bit_decoder.sv
// Top level of the signed Golomb bit decoder.
//
// Usage:
//   The coded stream enters one bit per transaction on i_code_bit
//   (i_in_valid / o_in_ready). Each codeword is a sign bit, a unary run
//   of zeros closed by a one, then the remainder bits (plain binary for a
//   power-of-two divisor, truncated binary otherwise), MSB first.
//   Decoded values leave on o_value / o_overflow (o_out_valid / i_out_ready),
//   one transaction per finished codeword. A unary run of MAX_QUOTIENT
//   zeros yields one transaction with o_overflow set and o_value zero.
//   The divisor is written through i_divisor_we / i_divisor and takes
//   effect at the next sign bit; zero acts as one, values above
//   2**DIVISOR_WIDTH saturate to it.
// Timing:
//   One bit is accepted every cycle while the job queue has room. A result
//   reaches the output after the edge that accepts the bit closing its
//   codeword: the queue is written at that edge, then the multiply stage
//   and the output register follow. The back end sustains one result per
//   cycle through its single multiplier while the receiver is ready.
// Reset and stall:
//   Synchronous reset clears the parser to expect a sign bit, empties the
//   queue and sets the divisor to one. When the receiver stalls, the output
//   and multiply stages hold, the queue fills, and o_in_ready drops only
//   once the queue is full.
module signed_golomb_bit_decoder
    import sgbd_pkg::*;
#(
    parameter int DIVISOR_WIDTH = DEF_DIVISOR_WIDTH,
    parameter int MAX_QUOTIENT  = DEF_MAX_QUOTIENT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_divisor_we,
    input  logic [CFG_W-1:0]          i_divisor,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_code_bit,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_overflow
);

    localparam int QW    = $clog2(MAX_QUOTIENT + 1);
    localparam int EW    = DIVISOR_WIDTH + 1;
    localparam int RW    = DIVISOR_WIDTH;
    localparam int JOB_W = 2 + QW + EW + RW;

    logic             q_push, q_full, q_pop, q_valid;
    logic [JOB_W-1:0] front_job, q_job;

    // parse bits and hand finished codewords to the queue
    sgbd_front #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH),
        .MAX_QUOTIENT  (MAX_QUOTIENT),
        .QW            (QW),
        .EW            (EW),
        .RW            (RW),
        .JOB_W         (JOB_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_divisor_we (i_divisor_we),
        .i_divisor    (i_divisor),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_bit   (i_code_bit),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (front_job)
    );

    // decouple the parser from the arithmetic and the receiver
    sgbd_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    // form the signed value and drive the result channel
    sgbd_back #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH),
        .MAX_QUOTIENT  (MAX_QUOTIENT),
        .QW            (QW),
        .EW            (EW),
        .RW            (RW),
        .JOB_W         (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_overflow  (o_overflow)
    );

    // a job is only produced when the queue can take it
    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) q_push |-> !q_full
    ) else $error("job pushed into full queue");

    // an overflow result carries a zero value
    a_overflow_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_value == '0)
    ) else $error("overflow result with nonzero value");

    // saturation keeps the most negative code out of the result
    a_value_saturated: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_overflow) |-> (o_value != {1'b1, {(VALUE_W-1){1'b0}}})
    ) else $error("magnitude not saturated");

endmodule

// File: sv/sgbd_front.sv
// Front end: divisor register, bit parser and codeword job generation.
module sgbd_front
    import sgbd_pkg::*;
#(
    parameter int DIVISOR_WIDTH = DEF_DIVISOR_WIDTH,
    parameter int MAX_QUOTIENT  = DEF_MAX_QUOTIENT,
    parameter int QW            = $clog2(MAX_QUOTIENT + 1),
    parameter int EW            = DIVISOR_WIDTH + 1,
    parameter int RW            = DIVISOR_WIDTH,
    parameter int JOB_W         = 2 + QW + EW + RW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_divisor_we,
    input  logic [CFG_W-1:0] i_divisor,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_code_bit,
    input  logic             i_q_full,
    output logic             o_push,
    output logic [JOB_W-1:0] o_job
);

    localparam int CW = (CFG_W > EW) ? CFG_W : EW;
    localparam int BW = $clog2(DIVISOR_WIDTH + 1);

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_UNARY,
        PH_REM,
        PH_EXTRA
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CFG_W-1:0] r_divisor, n_divisor;
    logic             r_neg, n_neg;
    logic [QW-1:0]    r_quo, n_quo;
    logic [RW-1:0]    r_acc, n_acc;
    logic [BW-1:0]    r_taken, n_taken;
    logic [EW-1:0]    r_div, n_div;
    logic [BW-1:0]    r_need, n_need;
    logic             r_pow2, n_pow2;
    logic [RW-1:0]    r_u, n_u;

    // divisor decode, used when the sign bit latches it
    logic [CW-1:0] raw_ext, top_ext, eff_c;
    logic [EW-1:0] eff, eff_m1, two_b, u_full;
    logic [BW-1:0] b_cl, need_c;
    logic          pow2_c;

    always_comb begin
        raw_ext = CW'(r_divisor);
        top_ext = CW'(1) << DIVISOR_WIDTH;
        if (raw_ext == '0) begin
            eff_c = CW'(1);
        end else if (raw_ext > top_ext) begin
            eff_c = top_ext;
        end else begin
            eff_c = raw_ext;
        end
        eff    = eff_c[EW-1:0];
        eff_m1 = eff - EW'(1);
        b_cl   = '0;
        for (int k = 0; k < DIVISOR_WIDTH; k++) begin
            if (eff_m1[k]) b_cl = BW'(k + 1);
        end
        pow2_c = ((eff & eff_m1) == '0);
        need_c = pow2_c ? b_cl : (b_cl - BW'(1));
        two_b  = EW'(1) << b_cl;
        u_full = two_b - eff;
    end

    logic              accept;
    logic              emit, emit_ovf;
    logic [RW-1:0]     emit_rem;
    logic [RW:0]       shift_acc, extra_val;
    logic [RW-1:0]     acc_n;
    logic [BW-1:0]     taken_n;
    logic [QW-1:0]     quo_n;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        shift_acc = {r_acc, i_code_bit};
        acc_n     = shift_acc[RW-1:0];
        taken_n   = r_taken + BW'(1);
        quo_n     = r_quo + QW'(1);
        extra_val = shift_acc - (RW + 1)'(r_u);

        n_phase   = r_phase;
        n_divisor = i_divisor_we ? i_divisor : r_divisor;
        n_neg     = r_neg;
        n_quo     = r_quo;
        n_acc     = r_acc;
        n_taken   = r_taken;
        n_div     = r_div;
        n_need    = r_need;
        n_pow2    = r_pow2;
        n_u       = r_u;
        emit      = 1'b0;
        emit_ovf  = 1'b0;
        emit_rem  = '0;

        if (accept) begin
            unique case (r_phase)
                PH_SIGN: begin
                    n_neg   = i_code_bit;
                    n_div   = eff;
                    n_need  = need_c;
                    n_pow2  = pow2_c;
                    n_u     = u_full[RW-1:0];
                    n_quo   = '0;
                    n_acc   = '0;
                    n_taken = '0;
                    n_phase = PH_UNARY;
                end
                PH_UNARY: begin
                    if (i_code_bit) begin
                        if (r_need == '0) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = PH_REM;
                        end
                    end else if (quo_n >= QW'(MAX_QUOTIENT)) begin
                        emit     = 1'b1;
                        emit_ovf = 1'b1;
                    end else begin
                        n_quo = quo_n;
                    end
                end
                PH_REM: begin
                    n_acc   = acc_n;
                    n_taken = taken_n;
                    if (taken_n >= r_need) begin
                        if (r_pow2 || (acc_n < r_u)) begin
                            emit     = 1'b1;
                            emit_rem = acc_n;
                        end else begin
                            n_phase = PH_EXTRA;
                        end
                    end
                end
                PH_EXTRA: begin
                    emit     = 1'b1;
                    emit_rem = extra_val[RW-1:0];
                end
                default: n_phase = PH_SIGN;
            endcase
            if (emit) begin
                n_phase = PH_SIGN;
                n_quo   = '0;
                n_acc   = '0;
                n_taken = '0;
            end
        end
    end

    assign o_push = emit;
    assign o_job  = {r_neg, emit_ovf, r_quo, r_div, emit_rem};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIGN;
            r_divisor <= DIVISOR_RESET;
            r_neg     <= 1'b0;
            r_quo     <= '0;
            r_acc     <= '0;
            r_taken   <= '0;
            r_div     <= EW'(1);
            r_need    <= '0;
            r_pow2    <= 1'b1;
            r_u       <= '0;
        end else begin
            r_phase   <= n_phase;
            r_divisor <= n_divisor;
            r_neg     <= n_neg;
            r_quo     <= n_quo;
            r_acc     <= n_acc;
            r_taken   <= n_taken;
            r_div     <= n_div;
            r_need    <= n_need;
            r_pow2    <= n_pow2;
            r_u       <= n_u;
        end
    end

endmodule

// File: sv/sgbd_queue.sv
// Small job queue between the front end and the back end.
module sgbd_queue
    import sgbd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [NW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + NW'(1);
            2'b01:   n_count = r_count - NW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/sgbd_back.sv
// Back end: magnitude multiply, saturation, sign and output register.
module sgbd_back
    import sgbd_pkg::*;
#(
    parameter int DIVISOR_WIDTH = DEF_DIVISOR_WIDTH,
    parameter int MAX_QUOTIENT  = DEF_MAX_QUOTIENT,
    parameter int QW            = $clog2(MAX_QUOTIENT + 1),
    parameter int EW            = DIVISOR_WIDTH + 1,
    parameter int RW            = DIVISOR_WIDTH,
    parameter int JOB_W         = 2 + QW + EW + RW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    input  logic [JOB_W-1:0]          i_job,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_overflow
);

    localparam int MW = QW + EW + 1;
    localparam int SW = (MW > VALUE_W) ? MW : VALUE_W;

    logic [RW-1:0] job_rem;
    logic [EW-1:0] job_div;
    logic [QW-1:0] job_quo;
    logic          job_ovf, job_neg;

    assign job_rem = i_job[RW-1:0];
    assign job_div = i_job[RW +: EW];
    assign job_quo = i_job[RW + EW +: QW];
    assign job_ovf = i_job[RW + EW + QW];
    assign job_neg = i_job[RW + EW + QW + 1];

    // stage A: quotient times divisor plus remainder
    logic          r_a_valid, r_a_neg, r_a_ovf;
    logic [MW-1:0] r_a_mag;
    // output stage
    logic                      r_o_valid, r_o_ovf;
    logic signed [VALUE_W-1:0] r_o_value;

    logic out_can, a_can, a_load, o_load;

    assign out_can = !r_o_valid || i_out_ready;
    assign a_can   = !r_a_valid || out_can;
    assign o_pop   = i_job_valid && a_can;
    assign a_load  = o_pop;
    assign o_load  = r_a_valid && out_can;

    logic [SW-1:0]      mag_ext;
    logic [VALUE_W-1:0] mag_sat, val_c;

    always_comb begin
        mag_ext = SW'(r_a_mag);
        if (mag_ext > SW'(MAG_LIMIT)) begin
            mag_sat = VALUE_W'(MAG_LIMIT);
        end else begin
            mag_sat = mag_ext[VALUE_W-1:0];
        end
        if (r_a_ovf) begin
            val_c = '0;
        end else if (r_a_neg) begin
            val_c = '0 - mag_sat;
        end else begin
            val_c = mag_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_can) r_a_valid <= i_job_valid;
            if (out_can) r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_neg <= job_neg;
            r_a_ovf <= job_ovf;
            r_a_mag <= MW'(MW'(job_quo) * MW'(job_div)) + MW'(job_rem);
        end
        if (o_load) begin
            r_o_ovf   <= r_a_ovf;
            r_o_value <= val_c;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_value     = r_o_value;
    assign o_overflow  = r_o_ovf;

endmodule
